>>> sv/positional_list_buffer_top_assert.svh
// Assertion macros for the positional list buffer checker.
`ifndef POSITIONAL_LIST_BUFFER_TOP_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/plb_pkg.sv
// Package for the positional list buffer: sizes, codes and shared types.
package plb_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    // Width for position compares against count + 1
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Stream packing
    localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_TDATA_W = ((VALUE_W + ENTRY_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = STATUS_W;
    localparam int OUT_CNT_LO  = VALUE_W;
    localparam int OUT_CNT_HI  = VALUE_W + ENTRY_W - 1;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 4'd0,
        CMD_INS_END   = 4'd1,
        CMD_INS_POS   = 4'd2,
        CMD_DEL_FRONT = 4'd3,
        CMD_DEL_END   = 4'd4,
        CMD_DEL_POS   = 4'd5,
        CMD_SHOW      = 4'd6,
        CMD_REVERSE   = 4'd7,
        CMD_CLEAR     = 4'd8
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    // Per-cell operation
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    // Edit applied to the whole chain
    typedef enum logic [1:0] {
        EDIT_NONE,
        EDIT_INS,
        EDIT_DEL
    } t_edit;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SHOW
    } t_state;

    // Controller to chain
    typedef struct packed {
        t_edit              kind;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   rd_idx;
    } t_chain_ctl;

endpackage

>>> sv/plb_cell.sv
// One storage cell of the list chain.
module plb_cell (
    input  logic                        i_clk,
    input  plb_pkg::t_cell_op           i_op,
    input  logic [plb_pkg::VALUE_W-1:0] i_load,
    input  logic [plb_pkg::VALUE_W-1:0] i_left,
    input  logic [plb_pkg::VALUE_W-1:0] i_right,
    output logic [plb_pkg::VALUE_W-1:0] o_value
);
    import plb_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    // Next value: hold, load, or take from a neighbor
    always_comb begin
        unique case (i_op)
            CELL_HOLD:       n_value = r_value;
            CELL_LOAD:       n_value = i_load;
            CELL_FROM_LEFT:  n_value = i_left;
            CELL_FROM_RIGHT: n_value = i_right;
            default:         n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> sv/plb_ctrl.sv
// Command decoder, count, display sequencer and output register.
module plb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_valid,
    output logic                            o_s_ready,
    input  logic [plb_pkg::CMD_W-1:0]       i_cmd,
    input  logic [plb_pkg::VALUE_W-1:0]     i_value,
    input  logic [plb_pkg::POS_W-1:0]       i_pos,
    output logic                            o_m_valid,
    input  logic                            i_m_ready,
    output logic [plb_pkg::STATUS_W-1:0]    o_m_status,
    output logic [plb_pkg::VALUE_W-1:0]     o_m_value,
    output logic [plb_pkg::ENTRY_W-1:0]     o_m_count,
    output logic                            o_m_last,
    output plb_pkg::t_chain_ctl             o_chain,
    input  logic [plb_pkg::VALUE_W-1:0]     i_rd_value
);
    import plb_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_i, n_i;
    logic                r_dir, n_dir;
    logic                r_m_valid, n_m_valid;
    t_status             r_m_status, n_m_status;
    logic [VALUE_W-1:0]  r_m_value, n_m_value;
    logic [ENTRY_W-1:0]  r_m_count, n_m_count;
    logic                r_m_last, n_m_last;

    logic                slot_free;
    logic                s_ready;
    logic                load;
    t_status             res_status;
    logic [VALUE_W-1:0]  res_value;
    logic                res_last;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    last_idx;
    logic                is_full;
    logic                is_empty;
    t_cmd                cmd;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_i       <= '0;
            r_dir     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_i       <= n_i;
            r_dir     <= n_dir;
            r_m_valid <= n_m_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_m_status <= n_m_status;
        r_m_value  <= n_m_value;
        r_m_count  <= n_m_count;
        r_m_last   <= n_m_last;
    end

    // Shared decode terms
    assign cmd      = t_cmd'(i_cmd);
    assign pos_ext  = CMP_W'(i_pos);
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_idx  = IDX_W'(i_pos - POS_W'(1));
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    // Next state, chain edit and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_dir      = r_dir;
        n_m_valid  = r_m_valid && !i_m_ready;
        n_m_status = r_m_status;
        n_m_value  = r_m_value;
        n_m_count  = r_m_count;
        n_m_last   = r_m_last;

        o_chain.kind   = EDIT_NONE;
        o_chain.idx    = '0;
        o_chain.value  = i_value;
        o_chain.rd_idx = '0;

        slot_free  = !r_m_valid || i_m_ready;
        s_ready    = 1'b0;
        load       = 1'b0;
        res_status = STAT_OK;
        res_value  = '0;
        res_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                s_ready = slot_free;
                if (s_ready && i_s_valid) begin
                    load = 1'b1;
                    unique case (cmd)
                        CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
                            if (cmd == CMD_INS_POS &&
                                (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                                res_status = STAT_BADPOS;
                            end else if (is_full) begin
                                res_status = STAT_FULL;
                            end else begin
                                o_chain.kind = EDIT_INS;
                                if (cmd == CMD_INS_FRONT) begin
                                    o_chain.idx = '0;
                                end else if (cmd == CMD_INS_END) begin
                                    o_chain.idx = IDX_W'(r_count);
                                end else begin
                                    o_chain.idx = pos_idx;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
                            if (is_empty) begin
                                res_status = STAT_EMPTY;
                            end else if (cmd == CMD_DEL_POS &&
                                         (pos_ext == '0 || pos_ext > cnt_ext)) begin
                                res_status = STAT_BADPOS;
                            end else begin
                                o_chain.kind = EDIT_DEL;
                                if (cmd == CMD_DEL_FRONT) begin
                                    o_chain.idx = '0;
                                end else if (cmd == CMD_DEL_END) begin
                                    o_chain.idx = last_idx;
                                end else begin
                                    o_chain.idx = pos_idx;
                                end
                                o_chain.rd_idx = o_chain.idx;
                                res_value      = i_rd_value;
                                n_count        = r_count - CNT_W'(1);
                            end
                        end
                        CMD_SHOW, CMD_REVERSE: begin
                            if (is_empty) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                // elements go out from the display state
                                load    = 1'b0;
                                n_state = S_SHOW;
                                n_i     = '0;
                                n_dir   = (cmd == CMD_REVERSE);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            // undefined command: plain ok result
                        end
                    endcase
                end
            end
            S_SHOW: begin
                if (slot_free) begin
                    load           = 1'b1;
                    o_chain.rd_idx = r_dir ? (last_idx - r_i) : r_i;
                    res_value      = i_rd_value;
                    res_last       = (r_i == last_idx);
                    n_i            = r_i + IDX_W'(1);
                    if (res_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the output register
        if (load) begin
            n_m_valid  = 1'b1;
            n_m_status = res_status;
            n_m_value  = res_value;
            n_m_count  = ENTRY_W'(n_count);
            n_m_last   = res_last;
        end
    end

    assign o_s_ready  = s_ready;
    assign o_m_valid  = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_value  = r_m_value;
    assign o_m_count  = r_m_count;
    assign o_m_last   = r_m_last;

endmodule

>>> sv/positional_list_buffer_top.sv
// Positional list buffer: a row of value cells with a command controller.
// Usage:
//   Input beats carry one command each: s_axis_tuser holds the command,
//   s_axis_tdata the value to insert and the 1-based position.
//   Every command gives one output beat, except a display of a non-empty
//   list, which gives one beat per element with m_axis_tlast on the final one.
//   m_axis_tuser carries the status, m_axis_tdata the deleted or displayed
//   value and the element count after the command.
// Timing:
//   Inserts and deletes shift the whole cell row at acceptance; clear only
//   resets the count. The result is in the output register in the cycle after
//   acceptance; such commands may follow each other every cycle unless a
//   result stalls. A display enters the display state, then loads one element
//   per cycle unless stalled; no command is accepted until its last beat loads.
// Reset:
//   The count clears and the output register empties; cell contents are not
//   cleared and are never shown until written.
// Stalls:
//   A result held by a low m_axis_tready keeps s_axis_tready low and pauses
//   a display in progress; nothing is dropped.
module positional_list_buffer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // item_value [31:0], position [39:32]
    input  logic [plb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd [3:0]
    input  logic [plb_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_value [31:0], entry_count [36:32], zero fill above
    output logic [plb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status [1:0]
    output logic [plb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // last_result
    output logic                                m_axis_tlast
);
    import plb_pkg::*;

    t_chain_ctl          chain;
    logic [VALUE_W-1:0]  cell_val [CAPACITY];
    t_cell_op            cell_op  [CAPACITY];
    logic [VALUE_W-1:0]  rd_value;
    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_value;
    logic [ENTRY_W-1:0]  m_count;

    // Controller
    plb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_cmd      (s_axis_tuser[CMD_W-1:0]),
        .i_value    (s_axis_tdata[VALUE_W-1:0]),
        .i_pos      (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_status (m_status),
        .o_m_value  (m_value),
        .o_m_count  (m_count),
        .o_m_last   (m_axis_tlast),
        .o_chain    (chain),
        .i_rd_value (rd_value)
    );

    // Cell row: insert shifts toward the end, delete toward the front
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(g);
        logic [VALUE_W-1:0] left_val;
        logic [VALUE_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        always_comb begin
            cell_op[g] = CELL_HOLD;
            if (chain.kind == EDIT_INS) begin
                if (MY_IDX == chain.idx) begin
                    cell_op[g] = CELL_LOAD;
                end else if (MY_IDX > chain.idx) begin
                    cell_op[g] = CELL_FROM_LEFT;
                end
            end else if (chain.kind == EDIT_DEL) begin
                if (MY_IDX >= chain.idx) begin
                    cell_op[g] = CELL_FROM_RIGHT;
                end
            end
        end

        plb_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_load  (chain.value),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g])
        );
    end

    // Read bus: the selected cell drives the value
    always_comb begin
        rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (chain.rd_idx == IDX_W'(k)) begin
                rd_value = rd_value | cell_val[k];
            end
        end
    end

    assign m_axis_tdata = OUT_TDATA_W'({m_count, m_value});
    assign m_axis_tuser = m_status;

endmodule

>>> sv/plb_checker.sv
// Port-level checker for the positional list buffer, bound to the top level.
`include "positional_list_buffer_top_assert.svh"

module plb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [plb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [plb_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                            m_axis_tlast
);
    import plb_pkg::*;

    logic [ENTRY_W-1:0]  out_count;
    logic [VALUE_W-1:0]  out_value;
    logic                in_beat;

    assign out_count = m_axis_tdata[OUT_CNT_HI:OUT_CNT_LO];
    assign out_value = m_axis_tdata[VALUE_W-1:0];
    assign in_beat   = s_axis_tvalid && s_axis_tready;

    // A stalled result beat holds
    `PLB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output beat changed under stall")

    // Full status only with a full list
    `PLB_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tuser == STAT_FULL,
        out_count == ENTRY_W'(CAPACITY), "full status with list not full")

    // Empty status only with no elements
    `PLB_ASSERT_NOW(a_empty_count, m_axis_tvalid && m_axis_tuser == STAT_EMPTY,
        out_count == '0, "empty status with elements present")

    // Any error ends the command with a zero value
    `PLB_ASSERT_NOW(a_err_last, m_axis_tvalid && m_axis_tuser != STAT_OK,
        m_axis_tlast && out_value == '0, "error beat not final or value not zero")

    // The element count never passes capacity
    `PLB_ASSERT_NOW(a_count_max, m_axis_tvalid || in_beat,
        !m_axis_tvalid || out_count <= ENTRY_W'(CAPACITY), "entry count above capacity")

endmodule

bind positional_list_buffer_top plb_checker u_plb_checker (.*);
